// ----- rtl/core/ehq_pkg.sv -----
package ehq_pkg;

  localparam int unsigned CAPACITY = 1024;
  // heap index width and held-count width
  localparam int unsigned AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // child index width: 2*pos+2 must not wrap
  localparam int unsigned IW = AW + 2;
  localparam int unsigned ECW = 11;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [31:0] event_time;
    logic [7:0]  event_kind;
    logic [15:0] patient_id;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  typedef struct packed {
    logic        opcode;
    logic [31:0] event_time;
    logic [7:0]  event_kind;
    logic [15:0] patient_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [31:0]    out_time;
    logic [7:0]     out_kind;
    logic [15:0]    out_patient;
    logic           is_empty;
    logic [ECW-1:0] entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_EX_ROOT,
    S_EX_LAST,
    S_DN_L,
    S_DN_R,
    S_RESULT
  } state_e;

endpackage

// ----- rtl/core/ehq_ram.sv -----
module ehq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/event_min_heap_queue.sv -----
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o   in_item_i  (in_item_t)
// out      output     out_valid_o / out_stall_i out_item_o (out_item_t)
//
// One item at a time; the next item is taken once the current result sits in
// the output register. Insert sifts the new entry up level by level; a full
// queue refuses it. Extract reads the root and the last entry, then sifts the
// last entry down level by level; an empty queue refuses it.
// Going up costs one heap RAM read per level, going down one or two.
// Reset clears the state, the count and the output valid only; a stalled result holds and blocks the next one.
module event_min_heap_queue
  import ehq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  entry_t          x_q, x_d;
  logic [AW-1:0]   pos_q, pos_d;
  entry_t          cand_q, cand_d;
  logic [AW-1:0]   cand_idx_q, cand_idx_d;
  logic            cand_ok_q, cand_ok_d;
  status_e         status_q, status_d;
  entry_t          odata_q, odata_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [EW-1:0]   ram_rdata;
  entry_t          rd;

  logic [AW-1:0]   par_idx;
  logic [IW-1:0]   lc_w, rc_w, cnt_w, nlc_w;
  logic            dn_eval, mv;
  entry_t          c_ent;
  logic [AW-1:0]   c_idx;
  logic [31:0]     best_time;

  ehq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
    parent_of = AW'((p - 1'b1) >> 1);
  endfunction

  assign par_idx = parent_of(pos_q);
  assign cnt_w   = IW'(count_q);
  assign lc_w    = (IW'(pos_q) << 1) | IW'(1);
  assign rc_w    = (IW'(pos_q) << 1) + IW'(2);
  assign nlc_w   = (IW'(c_idx) << 1) | IW'(1);

  // sift-down step: pick the child that takes the hole, if any
  always_comb begin
    dn_eval   = 1'b0;
    mv        = 1'b0;
    c_ent     = rd;
    c_idx     = AW'(lc_w);
    best_time = cand_ok_q ? cand_q.event_time : x_q.event_time;
    case (state_q)
      S_DN_L: begin
        if (!(rc_w < cnt_w)) begin
          dn_eval = 1'b1;
          mv      = rd.event_time < x_q.event_time;
        end
      end
      S_DN_R: begin
        dn_eval = 1'b1;
        if (rd.event_time < best_time) begin
          mv    = 1'b1;
          c_idx = AW'(rc_w);
        end else begin
          mv    = cand_ok_q;
          c_ent = cand_q;
          c_idx = cand_idx_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    x_d         = x_q;
    pos_d       = pos_q;
    cand_d      = cand_q;
    cand_idx_d  = cand_idx_q;
    cand_ok_d   = cand_ok_q;
    status_d    = status_q;
    odata_d     = odata_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = x_q;
    ram_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          odata_d  = '0;
          status_d = ST_OK;
          x_d      = '{event_time: in_item_i.event_time,
                       event_kind: in_item_i.event_kind,
                       patient_id: in_item_i.patient_id};
          if (in_item_i.opcode == OP_INSERT) begin
            if (count_q >= CW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_RESULT;
            end else begin
              count_d = count_q + 1'b1;
              pos_d   = AW'(count_q);
              if (count_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = x_d;
                state_d   = S_RESULT;
              end else begin
                ram_raddr = parent_of(AW'(count_q));
                state_d   = S_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_RESULT;
            end else begin
              count_d   = count_q - 1'b1;
              ram_raddr = '0;
              state_d   = S_EX_ROOT;
            end
          end
        end
      end
      S_UP: begin
        ram_we = 1'b1;
        if (rd.event_time > x_q.event_time) begin
          // parent moves down into the hole
          ram_wdata = rd;
          pos_d     = par_idx;
          if (par_idx == '0) begin
            state_d = S_PUT;
          end else begin
            ram_raddr = parent_of(par_idx);
          end
        end else begin
          state_d = S_RESULT;
        end
      end
      S_PUT: begin
        ram_we  = 1'b1;
        state_d = S_RESULT;
      end
      S_EX_ROOT: begin
        odata_d   = rd;
        ram_raddr = AW'(count_q);
        state_d   = S_EX_LAST;
      end
      S_EX_LAST: begin
        x_d   = rd;
        pos_d = '0;
        if (cnt_w > IW'(1)) begin
          ram_raddr = AW'(1);
          state_d   = S_DN_L;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = rd;
          state_d   = S_RESULT;
        end
      end
      S_DN_L, S_DN_R: begin
        if (!dn_eval) begin
          // right child exists: hold the left one and fetch the right
          cand_d     = rd;
          cand_idx_d = AW'(lc_w);
          cand_ok_d  = rd.event_time < x_q.event_time;
          ram_raddr  = AW'(rc_w);
          state_d    = S_DN_R;
        end else if (mv) begin
          ram_we    = 1'b1;
          ram_wdata = c_ent;
          pos_d     = c_idx;
          if (nlc_w < cnt_w) begin
            ram_raddr = AW'(nlc_w);
            state_d   = S_DN_L;
          end else begin
            state_d = S_PUT;
          end
        end else begin
          ram_we  = 1'b1;
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = '{status:      status_q,
                          out_time:    odata_q.event_time,
                          out_kind:    odata_q.event_kind,
                          out_patient: odata_q.patient_id,
                          is_empty:    (count_q == '0),
                          entry_count: ECW'(count_q)};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    pos_q      <= pos_d;
    cand_q     <= cand_d;
    cand_idx_q <= cand_idx_d;
    cand_ok_q  <= cand_ok_d;
    status_q   <= status_d;
    odata_q    <= odata_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/core/ehq_checker.sv -----
module ehq_checker
  import ehq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // one item in flight: an accepted item blocks the input next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // refused extract: empty queue, zero payload
  a_empty_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_EMPTY |->
      out_item_o.is_empty && out_item_o.entry_count == '0 &&
      out_item_o.out_time == '0 && out_item_o.out_kind == '0 &&
      out_item_o.out_patient == '0)
    else $error("bad empty refusal");

  // refused insert only at capacity
  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_FULL |->
      out_item_o.entry_count == ECW'(CAPACITY) && !out_item_o.is_empty)
    else $error("bad full refusal");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_empty |-> out_item_o.entry_count == '0)
    else $error("empty flag with nonzero count");

endmodule

bind event_min_heap_queue ehq_checker u_ehq_checker (.*);
